>>> design/gcpr_pkg.sv
// Shared types and constants for the grid color path reachability block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package gcpr_pkg;

	// Fixed field widths of the channel payloads.
	localparam int CELL_IDX_W = 6;
	localparam int COLOR_W    = 4;

	// Default side length of the square map.
	localparam int GRID_SIDE_DEF = 8;

	// Probe slots per cell: one per direction plus one to check the last probe.
	localparam int SLOT_W = 3;
	localparam logic [SLOT_W-1:0] PROBE_SLOTS = SLOT_W'(4);

	// Input item: a cell write or a reachability query.
	typedef struct packed {
		logic                  mode;
		logic [CELL_IDX_W-1:0] cell_index;
		logic [COLOR_W-1:0]    cell_color;
		logic [CELL_IDX_W-1:0] start_cell;
		logic [CELL_IDX_W-1:0] target_cell;
		logic [COLOR_W-1:0]    path_color;
	} req_t;

	// Result item.
	typedef struct packed {
		logic reachable;
		logic is_answer;
	} rsp_t;

	// Item kinds carried in the mode field.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Neighbor directions, in probe order.
	typedef enum logic [1:0] {
		DIR_UP,
		DIR_RIGHT,
		DIR_DOWN,
		DIR_LEFT
	} dir_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_PROBE,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write_cell;
		logic start_search;
		logic pop;
		logic load_cur;
		logic issue;
		dir_t dir;
		logic check;
		logic rsp_load;
		logic rsp_reach;
		logic rsp_answer;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_hit;
		logic start_oob;
		logic depth_zero;
		logic hit;
		logic rsp_free;
	} sts_t;

endpackage

`default_nettype wire

>>> design/gcpr_if.sv
// Valid/ready channel interfaces for the request and result items.
// Depends on gcpr_pkg for the payload types.
`default_nettype none

interface gcpr_req_if;
	logic          valid;
	logic          ready;
	gcpr_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gcpr_rsp_if;
	logic          valid;
	logic          ready;
	gcpr_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/gcpr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module gcpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> design/gcpr_ctrl.sv
// Controller state machine: item acceptance, search sequencing and result hand-off.
// Depends on gcpr_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module gcpr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_mode,
	output logic             req_ready,
	input  gcpr_pkg::sts_t   sts,
	output gcpr_pkg::cmd_t   cmd
);

	gcpr_pkg::state_t                  state_q, state_d;
	logic [gcpr_pkg::SLOT_W-1:0]       slot_q, slot_d;
	logic                              pend_reach_q, pend_reach_d;
	logic                              pend_answer_q, pend_answer_d;

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= gcpr_pkg::ST_IDLE;
			slot_q        <= '0;
			pend_reach_q  <= 1'b0;
			pend_answer_q <= 1'b0;
		end else begin
			state_q       <= state_d;
			slot_q        <= slot_d;
			pend_reach_q  <= pend_reach_d;
			pend_answer_q <= pend_answer_d;
		end
	end

	// Next state. A result that cannot go to the output register yet waits in ST_RESP.
	always_comb begin
		state_d       = state_q;
		slot_d        = slot_q;
		pend_reach_d  = pend_reach_q;
		pend_answer_d = pend_answer_q;
		unique case (state_q)
			gcpr_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_mode == gcpr_pkg::MODE_WRITE) begin
						pend_reach_d  = 1'b0;
						pend_answer_d = 1'b0;
						if (!sts.rsp_free) begin
							state_d = gcpr_pkg::ST_RESP;
						end
					end else if (sts.start_hit || sts.start_oob) begin
						pend_reach_d  = sts.start_hit;
						pend_answer_d = 1'b1;
						if (!sts.rsp_free) begin
							state_d = gcpr_pkg::ST_RESP;
						end
					end else begin
						state_d = gcpr_pkg::ST_POP;
					end
				end
			end
			gcpr_pkg::ST_POP: begin
				if (sts.depth_zero) begin
					pend_reach_d  = 1'b0;
					pend_answer_d = 1'b1;
					state_d       = sts.rsp_free ? gcpr_pkg::ST_IDLE : gcpr_pkg::ST_RESP;
				end else begin
					slot_d  = '0;
					state_d = gcpr_pkg::ST_PROBE;
				end
			end
			gcpr_pkg::ST_PROBE: begin
				if (sts.hit) begin
					pend_reach_d  = 1'b1;
					pend_answer_d = 1'b1;
					state_d       = sts.rsp_free ? gcpr_pkg::ST_IDLE : gcpr_pkg::ST_RESP;
				end else if (slot_q == gcpr_pkg::PROBE_SLOTS) begin
					state_d = gcpr_pkg::ST_POP;
				end else begin
					slot_d = slot_q + 1'b1;
				end
			end
			gcpr_pkg::ST_RESP: begin
				if (sts.rsp_free) begin
					state_d = gcpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gcpr_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs: handshake ready and datapath commands.
	always_comb begin
		cmd       = '0;
		cmd.dir   = gcpr_pkg::DIR_UP;
		req_ready = (state_q == gcpr_pkg::ST_IDLE);
		unique case (state_q)
			gcpr_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_mode == gcpr_pkg::MODE_WRITE) begin
						cmd.write_cell = 1'b1;
						cmd.rsp_load   = sts.rsp_free;
					end else if (sts.start_hit || sts.start_oob) begin
						cmd.rsp_load   = sts.rsp_free;
						cmd.rsp_reach  = sts.start_hit;
						cmd.rsp_answer = 1'b1;
					end else begin
						cmd.start_search = 1'b1;
					end
				end
			end
			gcpr_pkg::ST_POP: begin
				if (sts.depth_zero) begin
					cmd.rsp_load   = sts.rsp_free;
					cmd.rsp_answer = 1'b1;
				end else begin
					cmd.pop = 1'b1;
				end
			end
			gcpr_pkg::ST_PROBE: begin
				cmd.load_cur = (slot_q == '0);
				cmd.issue    = (slot_q != gcpr_pkg::PROBE_SLOTS);
				cmd.dir      = gcpr_pkg::dir_t'(slot_q[1:0]);
				cmd.check    = (slot_q != '0);
				if (sts.hit) begin
					cmd.rsp_load   = sts.rsp_free;
					cmd.rsp_reach  = 1'b1;
					cmd.rsp_answer = 1'b1;
				end
			end
			gcpr_pkg::ST_RESP: begin
				cmd.rsp_load   = sts.rsp_free;
				cmd.rsp_reach  = pend_reach_q;
				cmd.rsp_answer = pend_answer_q;
			end
			default: begin
				cmd.rsp_load = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/gcpr_dp.sv
// Datapath: color map, visited marks, search stack, neighbor probe pipeline, result register.
// Depends on gcpr_pkg and gcpr_ram; controlled by gcpr_ctrl through cmd_t and sts_t.
`default_nettype none

module gcpr_dp #(
	parameter int GRID_SIDE = gcpr_pkg::GRID_SIDE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gcpr_pkg::req_t req_data,
	input  logic           rsp_ready,
	output logic           rsp_valid,
	output gcpr_pkg::rsp_t rsp_data,
	input  gcpr_pkg::cmd_t cmd,
	output gcpr_pkg::sts_t sts
);

	localparam int CELLS    = GRID_SIDE * GRID_SIDE;
	localparam int AW       = $clog2(CELLS);
	localparam int RW       = $clog2(GRID_SIDE);
	localparam int IW       = gcpr_pkg::CELL_IDX_W;
	localparam int CLW      = gcpr_pkg::COLOR_W;
	localparam int CW       = (AW > IW) ? AW : IW;
	localparam int RECIP_SH = 12;
	localparam int RECIP    = ((1 << RECIP_SH) + GRID_SIDE - 1) / GRID_SIDE;
	localparam int PW       = IW + RECIP_SH + 1;

	localparam logic [CW:0]   CELLS_C = (CW + 1)'(CELLS);
	localparam logic [RW-1:0] EDGE_C  = RW'(GRID_SIDE - 1);
	localparam logic [AW-1:0] SIDE_C  = AW'(GRID_SIDE);

	// Input item decode: range checks and start cell split into row and column.
	logic [CW-1:0] start_ext, index_ext, start_base, start_diff;
	logic [PW-1:0] start_prod;
	logic [RW-1:0] start_row, start_col;
	logic          write_ok;

	assign start_ext  = CW'(req_data.start_cell);
	assign index_ext  = CW'(req_data.cell_index);
	assign start_prod = PW'(req_data.start_cell) * PW'(RECIP);
	assign start_row  = start_prod[RECIP_SH +: RW];
	assign start_base = CW'(start_row) * CW'(GRID_SIDE);
	assign start_diff = start_ext - start_base;
	assign start_col  = start_diff[RW-1:0];
	assign write_ok   = ({1'b0, index_ext} < CELLS_C);

	assign sts.start_hit = (req_data.start_cell == req_data.target_cell);
	assign sts.start_oob = ({1'b0, start_ext} >= CELLS_C);

	// Query operands held for the whole search.
	logic [IW-1:0]  target_q;
	logic [CLW-1:0] color_q;

	always_ff @(posedge clk) begin
		if (cmd.start_search) begin
			target_q <= req_data.target_cell;
			color_q  <= req_data.path_color;
		end
	end

	// Current cell: taken from the stack read data in the first probe slot.
	logic [2*RW-1:0] stk_rdata;
	logic [RW-1:0]   cur_row_q, cur_col_q, cur_row, cur_col;

	assign cur_row = cmd.load_cur ? stk_rdata[2*RW-1:RW] : cur_row_q;
	assign cur_col = cmd.load_cur ? stk_rdata[RW-1:0] : cur_col_q;

	always_ff @(posedge clk) begin
		if (cmd.load_cur) begin
			cur_row_q <= stk_rdata[2*RW-1:RW];
			cur_col_q <= stk_rdata[RW-1:0];
		end
	end

	// Neighbor in the probed direction, with its bounds check.
	logic          nb_ok;
	logic [RW-1:0] nb_row, nb_col;
	logic [AW-1:0] nb_addr;

	always_comb begin
		nb_ok  = 1'b0;
		nb_row = cur_row;
		nb_col = cur_col;
		unique case (cmd.dir)
			gcpr_pkg::DIR_UP: begin
				nb_ok  = (cur_row != '0);
				nb_row = cur_row - 1'b1;
			end
			gcpr_pkg::DIR_RIGHT: begin
				nb_ok  = (cur_col != EDGE_C);
				nb_col = cur_col + 1'b1;
			end
			gcpr_pkg::DIR_DOWN: begin
				nb_ok  = (cur_row != EDGE_C);
				nb_row = cur_row + 1'b1;
			end
			gcpr_pkg::DIR_LEFT: begin
				nb_ok  = (cur_col != '0);
				nb_col = cur_col - 1'b1;
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	assign nb_addr = AW'(AW'(nb_row) * SIDE_C) + AW'(nb_col);

	// Probe stage: the map read is in flight while the previous probe is checked.
	logic          nb_ok_s1, cv_s1;
	logic [RW-1:0] nb_row_s1, nb_col_s1;
	logic [AW-1:0] nb_addr_s1;
	logic [CELLS-1:0] color_valid_q, visited_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_ok_s1 <= 1'b0;
			cv_s1    <= 1'b0;
		end else begin
			nb_ok_s1 <= cmd.issue && nb_ok;
			cv_s1    <= cmd.issue && nb_ok && color_valid_q[nb_addr];
		end
	end

	always_ff @(posedge clk) begin
		nb_row_s1  <= nb_row;
		nb_col_s1  <= nb_col;
		nb_addr_s1 <= nb_addr;
	end

	// Color map. A cell never written reads as empty through its valid bit.
	logic [CLW-1:0] clr_rdata, color_eff;

	gcpr_ram #(
		.WIDTH (CLW),
		.DEPTH (CELLS)
	) u_color_ram (
		.clk   (clk),
		.we    (cmd.write_cell && write_ok),
		.waddr (index_ext[AW-1:0]),
		.wdata (req_data.cell_color),
		.raddr (nb_addr),
		.rdata (clr_rdata)
	);

	assign color_eff = cv_s1 ? clr_rdata : '0;

	// Check stage: a fresh neighbor of the path color is marked and pushed.
	logic qual, push;

	assign qual    = nb_ok_s1 && !visited_q[nb_addr_s1] && (color_eff == color_q);
	assign push    = cmd.check && qual;
	assign sts.hit = qual && (CW'(nb_addr_s1) == CW'(target_q));

	// Valid bits of the color map and visited marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_valid_q <= '0;
			visited_q     <= '0;
		end else begin
			if (cmd.write_cell && write_ok) begin
				color_valid_q[index_ext[AW-1:0]] <= 1'b1;
			end
			if (cmd.start_search) begin
				visited_q <= CELLS'(1) << start_ext[AW-1:0];
			end else if (push) begin
				visited_q[nb_addr_s1] <= 1'b1;
			end
		end
	end

	// Search stack of {row, column} entries.
	logic [AW:0]       depth_q, depth_m1;
	logic              stk_we;
	logic [AW-1:0]     stk_waddr;
	logic [2*RW-1:0]   stk_wdata;

	assign depth_m1  = depth_q - 1'b1;
	assign stk_we    = cmd.start_search || push;
	assign stk_waddr = cmd.start_search ? '0 : depth_q[AW-1:0];
	assign stk_wdata = cmd.start_search ? {start_row, start_col} : {nb_row_s1, nb_col_s1};

	gcpr_ram #(
		.WIDTH (2 * RW),
		.DEPTH (CELLS)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (depth_m1[AW-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.start_search) begin
			depth_q <= (AW + 1)'(1);
		end else if (push) begin
			depth_q <= depth_q + 1'b1;
		end else if (cmd.pop) begin
			depth_q <= depth_m1;
		end
	end

	assign sts.depth_zero = (depth_q == '0);

	// Result register on the output channel.
	logic           rsp_valid_q;
	gcpr_pkg::rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.reachable <= cmd.rsp_reach;
			rsp_q.is_answer <= cmd.rsp_answer;
		end
	end

	assign sts.rsp_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;

endmodule

`default_nettype wire

>>> design/grid_color_path_reachability.sv
// Grid color path reachability: 4-connected search over a GRID_SIDE x GRID_SIDE color map.
// A write item's acknowledge is loaded into the output register when the item is accepted,
// or waits in ST_RESP while that register holds an untaken result; so does the answer to a
// query with start equal to target or start outside the map. A search makes one neighbor
// probe per cycle through the map RAM port, plus the stack pop before each cell.
// Reset clears all control state and the map reads as empty at once; there is no clearing pass.
`default_nettype none

module grid_color_path_reachability #(
	parameter int GRID_SIDE = gcpr_pkg::GRID_SIDE_DEF
) (
	input logic        clk,
	input logic        arst_n,
	gcpr_req_if.sink   req,
	gcpr_rsp_if.source rsp
);

	gcpr_pkg::cmd_t cmd;
	gcpr_pkg::sts_t sts;
	logic           ctl_ready;
	logic           dp_rsp_valid;
	gcpr_pkg::rsp_t dp_rsp_data;

	// Controller.
	gcpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.data.mode),
		.req_ready (ctl_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath.
	gcpr_dp #(
		.GRID_SIDE (GRID_SIDE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.rsp_ready (rsp.ready),
		.rsp_valid (dp_rsp_valid),
		.rsp_data  (dp_rsp_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign req.ready = ctl_ready;
	assign rsp.valid = dp_rsp_valid;
	assign rsp.data  = dp_rsp_data;

	// A map write only happens for an accepted write item.
	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_cell |-> (req.valid && req.ready && (req.data.mode == gcpr_pkg::MODE_WRITE)))
		else $error("map write without an accepted write item");

	// The stack is never popped when empty.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !sts.depth_zero)
		else $error("pop from an empty search stack");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> sts.rsp_free)
		else $error("result register overwritten");

	// Starting a search leaves the start cell on the stack.
	a_start_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_search |=> !sts.depth_zero)
		else $error("search started with an empty stack");

endmodule

`default_nettype wire

>>> bench/gcpr_reach_monitor.sv
// Result checker for the grid color path reachability block: keeps its own color map,
// predicts each result from the accepted requests and compares the results in order.
// Depends on gcpr_pkg for the payload types and the direction codes.
`timescale 1ns / 100ps

module gcpr_reach_monitor (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  gcpr_pkg::req_t  req_data,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  gcpr_pkg::rsp_t  rsp_data,
	output int              mismatch_count,
	output int              answers_owed
);
	import gcpr_pkg::*;

	localparam int SIDE  = GRID_SIDE_DEF;
	localparam int CELLS = SIDE * SIDE;

	// Shadow of the block's color map and the results still to come, oldest first.
	logic [COLOR_W-1:0] color_map [CELLS];
	rsp_t               awaited_answers [$];

	// Flood fill from the start cell; the start cell's own color does not matter.
	function automatic logic path_exists(input int from, input int to, input logic [COLOR_W-1:0] hue);
		logic [CELLS-1:0] seen;
		int frontier [$];
		int here;
		int row;
		int col;
		int nr;
		int nc;
		int nx;
		if (from == to)
			return 1'b1;
		if (from >= CELLS)
			return 1'b0;
		seen = '0;
		seen[from] = 1'b1;
		frontier.push_back(from);
		while (frontier.size() > 0) begin
			here = frontier.pop_back();
			if (here == to)
				return 1'b1;
			row = here / SIDE;
			col = here % SIDE;
			for (int d = 0; d < 4; d++) begin
				nr = row;
				nc = col;
				case (dir_t'(d))
					DIR_UP:    nr = row - 1;
					DIR_RIGHT: nc = col + 1;
					DIR_DOWN:  nr = row + 1;
					default:   nc = col - 1;
				endcase
				if (nr >= 0 && nr < SIDE && nc >= 0 && nc < SIDE) begin
					nx = nr * SIDE + nc;
					if (!seen[nx] && color_map[nx] == hue) begin
						seen[nx] = 1'b1;
						frontier.push_back(nx);
					end
				end
			end
		end
		return 1'b0;
	endfunction

	initial begin
		mismatch_count = 0;
		answers_owed = 0;
	end

	// Results are checked before the request of the same edge is predicted.
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				color_map[i] = '0;
			awaited_answers.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_answers.size() == 0) begin
					$error("result with no item outstanding: reachable=%0b is_answer=%0b",
						rsp_data.reachable, rsp_data.is_answer);
					mismatch_count++;
				end else begin
					want = awaited_answers.pop_front();
					if (rsp_data.reachable !== want.reachable) begin
						$error("reachable: expected %0b, actual %0b",
							want.reachable, rsp_data.reachable);
						mismatch_count++;
					end
					if (rsp_data.is_answer !== want.is_answer) begin
						$error("is_answer: expected %0b, actual %0b",
							want.is_answer, rsp_data.is_answer);
						mismatch_count++;
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req_data.mode == MODE_WRITE) begin
					if (int'(req_data.cell_index) < CELLS)
						color_map[req_data.cell_index] = req_data.cell_color;
					want.reachable = 1'b0;
					want.is_answer = 1'b0;
				end else begin
					want.reachable = path_exists(int'(req_data.start_cell),
						int'(req_data.target_cell), req_data.path_color);
					want.is_answer = 1'b1;
				end
				awaited_answers.push_back(want);
			end
		end
		answers_owed = awaited_answers.size();
	end

endmodule

>>> bench/grid_color_path_reachability_tb.sv
// Top of the testbench for the grid color path reachability block: clock, reset,
// request stimulus, result back-pressure and the verdict.
// Depends on gcpr_pkg, the channel interfaces, the block and gcpr_reach_monitor.
`timescale 1ns / 100ps

module grid_color_path_reachability_tb;
	import gcpr_pkg::*;

	localparam int SIDE        = GRID_SIDE_DEF;
	localparam int CELLS       = SIDE * SIDE;
	localparam int ITEM_TARGET = 950;
	localparam int DRAIN_WAIT  = 400;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   answers_owed;
	int   items_sent;
	int   cycle_count;
	bit   no_idle;

	gcpr_req_if req ();
	gcpr_rsp_if rsp ();

	grid_color_path_reachability u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	gcpr_reach_monitor u_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req.valid),
		.req_ready      (req.ready),
		.req_data       (req.data),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_data       (rsp.data),
		.mismatch_count (mismatch_count),
		.answers_owed   (answers_owed)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Colors cluster on a few codes so that regions connect, with any 4-bit code now and then.
	function automatic logic [COLOR_W-1:0] pick_color();
		if ($urandom_range(0, 3) != 0)
			return COLOR_W'($urandom_range(0, 2));
		return COLOR_W'($urandom_range(0, 15));
	endfunction

	// One random move to a 4-connected neighbor; a move off the map stays put.
	function automatic int walk_step(input int here);
		int row;
		int col;
		row = here / SIDE;
		col = here % SIDE;
		case (dir_t'($urandom_range(0, 3)))
			DIR_UP:    if (row > 0) row--;
			DIR_RIGHT: if (col < SIDE - 1) col++;
			DIR_DOWN:  if (row < SIDE - 1) row++;
			default:   if (col > 0) col--;
		endcase
		return row * SIDE + col;
	endfunction

	// Presents one item and returns at the falling edge after it is accepted.
	task automatic push_item(input req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.data <= item;
		do
			@(posedge clk);
		while (!req.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// The fields that the item's mode does not use carry random values.
	task automatic send_write(input int idx, input logic [COLOR_W-1:0] hue);
		req_t item;
		item.mode = MODE_WRITE;
		item.cell_index = CELL_IDX_W'(idx);
		item.cell_color = hue;
		item.start_cell = CELL_IDX_W'($urandom_range(0, 63));
		item.target_cell = CELL_IDX_W'($urandom_range(0, 63));
		item.path_color = COLOR_W'($urandom_range(0, 15));
		push_item(item);
	endtask

	task automatic send_query(input int from, input int to, input logic [COLOR_W-1:0] hue);
		req_t item;
		item.mode = MODE_QUERY;
		item.cell_index = CELL_IDX_W'($urandom_range(0, 63));
		item.cell_color = COLOR_W'($urandom_range(0, 15));
		item.start_cell = CELL_IDX_W'(from);
		item.target_cell = CELL_IDX_W'(to);
		item.path_color = hue;
		push_item(item);
	endtask

	// Result back-pressure: stalls of random length between runs of ready.
	initial begin
		rsp.ready = 1'b0;
		@(negedge clk);
		forever begin
			int hold;
			hold = pick_gap();
			if (hold > 0) begin
				rsp.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	// A run that hangs ends here.
	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int first;
		int here;
		int other;
		int steps;
		logic [COLOR_W-1:0] hue;
		req_t item;

		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		items_sent = 0;
		no_idle = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty map, colors at both ends of the code range,
		// start equal to target, an unchecked start color and a broken path.
		send_query(0, 0, 0);
		send_query(0, 63, 0);
		send_query(0, 63, 15);
		send_write(63, 15);
		send_write(0, 8);
		send_query(0, 63, 0);
		send_query(0, 63, 15);
		send_query(63, 0, 0);
		send_write(62, 15);
		send_write(61, 15);
		send_query(61, 63, 15);
		send_query(63, 63, 9);
		send_query(63, 61, 15);
		send_query(62, 0, 15);
		send_write(62, 0);
		send_query(61, 63, 15);
		send_query(1, 62, 0);
		send_write(0, 0);
		send_write(63, 0);
		send_query(0, 63, 0);

		// Random part: painted walks followed by queries along them, loose
		// writes and queries, and bursts of fully random items.
		while (items_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					hue = pick_color();
					first = $urandom_range(0, CELLS - 1);
					here = first;
					steps = $urandom_range(2, 12);
					repeat (steps) begin
						send_write(here, hue);
						here = walk_step(here);
					end
					send_query(first, here, hue);
					send_query($urandom_range(0, CELLS - 1), here, pick_color());
				end
				4, 5: begin
					send_write($urandom_range(0, CELLS - 1), pick_color());
				end
				6, 7, 8: begin
					first = $urandom_range(0, CELLS - 1);
					case ($urandom_range(0, 5))
						0: other = first;
						1, 2: begin
							other = first;
							repeat ($urandom_range(1, 6))
								other = walk_step(other);
						end
						default: other = $urandom_range(0, CELLS - 1);
					endcase
					send_query(first, other, pick_color());
				end
				default: begin
					repeat (5) begin
						item.mode = 1'($urandom_range(0, 1));
						item.cell_index = CELL_IDX_W'($urandom_range(0, 63));
						item.cell_color = COLOR_W'($urandom_range(0, 15));
						item.start_cell = CELL_IDX_W'($urandom_range(0, 63));
						item.target_cell = CELL_IDX_W'($urandom_range(0, 63));
						item.path_color = COLOR_W'($urandom_range(0, 15));
						push_item(item);
					end
				end
			endcase
		end
		req.valid <= 1'b0;
		no_idle = 1'b0;

		// Drain the outstanding results, then give the block time to misbehave.
		while (answers_owed != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
